### hdl/lfba_pkg.sv
`timescale 1ns / 1ps

package lfba_pkg;

   localparam int NumBlocksDefault = 1024;
   localparam int WordBits         = 64;
   localparam int BitIdxW          = 6;
   localparam int BlockIdW         = 10;
   localparam int CfgW             = 11;
   localparam int StatusW          = 2;

   localparam logic [CfgW-1:0] DiskBlocksReset = 11'd1024;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [StatusW-1:0] STATUS_ALLOCATED    = 2'd0;
   localparam logic [StatusW-1:0] STATUS_NO_FREE      = 2'd1;
   localparam logic [StatusW-1:0] STATUS_FREED        = 2'd2;
   localparam logic [StatusW-1:0] STATUS_OUT_OF_RANGE = 2'd3;

   typedef struct packed {
      logic                mode;
      logic [BlockIdW-1:0] block_id;
   } req_type;

   typedef struct packed {
      logic [StatusW-1:0]  status;
      logic [BlockIdW-1:0] granted_block;
   } rsp_type;

   typedef struct packed {
      logic [CfgW-1:0] disk_blocks;
   } csr_type;

endpackage

### hdl/lfba_chan_if.sv
`timescale 1ns / 1ps

interface lfba_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hdl/lfba_ram.sv
`timescale 1ns / 1ps

module lfba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/lfba_summary.sv
`timescale 1ns / 1ps

module lfba_summary #(
   parameter int WORDS = 16,
   parameter int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              upd_en,
   input  logic [WORD_W-1:0] upd_word,
   input  logic              upd_full,
   output logic              free_found,
   output logic [WORD_W-1:0] free_word
);
   logic [WORDS-1:0] word_full_ff;
   logic [WORDS-1:0] word_full_in;

   always_comb begin
      word_full_in = word_full_ff;
      if (upd_en) begin
         word_full_in[upd_word] = upd_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_full_ff <= '0;
      end else begin
         word_full_ff <= word_full_in;
      end
   end

   // lowest word that still has a free block
   always_comb begin
      free_found = 1'b0;
      free_word  = '0;
      for (int i = WORDS - 1; i >= 0; i--) begin
         if (!word_full_ff[i]) begin
            free_found = 1'b1;
            free_word  = WORD_W'(i);
         end
      end
   end
endmodule

### hdl/lowest_free_block_allocator_unit.sv
`timescale 1ns / 1ps

// First-fit disk block allocator. The used marks live in a RAM of 64-bit words,
// with one flip-flop per word flagging a full word. An allocate item takes the
// lowest free block below min(disk_blocks, NUM_BLOCKS); a free item clears the
// mark of block_id, or reports out of range. The bitmap word is read as an item
// is taken; in the execute state it is modified and written back and the result
// register loaded, the state holding while an earlier result is not yet taken;
// no new item is taken until it leaves that state. After reset the block sweeps
// every RAM word to all free and takes no item meanwhile; disk_blocks may be
// written at any idle time and always reads the new value for the next item.
module lowest_free_block_allocator_unit #(
   parameter int NUM_BLOCKS = lfba_pkg::NumBlocksDefault
) (
   input  logic        clock,
   input  logic        reset,
   lfba_chan_if.sink   req_chan,
   lfba_chan_if.source rsp_chan,
   lfba_chan_if.sink   csr_chan
);
   import lfba_pkg::*;

   localparam int MAP_WORDS = (NUM_BLOCKS + WordBits - 1) / WordBits;
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int SIZE_W0   = $clog2(NUM_BLOCKS + 1);
   localparam int SIZE_W    = (SIZE_W0 > CfgW) ? SIZE_W0 : CfgW;
   localparam int ID_W      = WORD_W + BitIdxW;
   localparam int CMP_W     = (ID_W > SIZE_W) ? ID_W : SIZE_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [WORD_W-1:0]   clr_ff, clr_in;
   logic [CfgW-1:0]     disk_blocks_ff;
   logic [SIZE_W-1:0]   size;

   logic                op_mode_ff, op_mode_in;
   logic [BlockIdW-1:0] op_blk_ff, op_blk_in;
   logic [WORD_W-1:0]   op_word_ff, op_word_in;
   logic                op_found_ff, op_found_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                free_found;
   logic [WORD_W-1:0]   free_word;
   logic                accept;
   logic                slot_free;
   logic                finish;

   logic                ram_wr_en;
   logic [WORD_W-1:0]   ram_wr_addr;
   logic [WordBits-1:0] ram_wr_data;
   logic [WordBits-1:0] ram_rd_data;

   logic                upd_en;
   logic                upd_full;

   logic                zero_found;
   logic [BitIdxW-1:0]  zero_bit;
   logic [ID_W-1:0]     alloc_id;
   logic [WordBits-1:0] bit_mask;

   assign size = (SIZE_W'(disk_blocks_ff) > SIZE_W'(NUM_BLOCKS))
               ? SIZE_W'(NUM_BLOCKS) : SIZE_W'(disk_blocks_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && (state_ff == ST_IDLE);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign finish         = (state_ff == ST_EXEC) && slot_free;

   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   lfba_summary #(
      .WORDS (MAP_WORDS),
      .WORD_W(WORD_W)
   ) u_summary (
      .clock     (clock),
      .reset     (reset),
      .upd_en    (upd_en),
      .upd_word  (op_word_ff),
      .upd_full  (upd_full),
      .free_found(free_found),
      .free_word (free_word)
   );

   lfba_ram #(
      .WIDTH (WordBits),
      .DEPTH (MAP_WORDS),
      .ADDR_W(WORD_W)
   ) u_map_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (accept),
      .rd_addr(op_word_in),
      .rd_data(ram_rd_data)
   );

   // lowest clear bit of the word read back
   always_comb begin
      zero_found = 1'b0;
      zero_bit   = '0;
      for (int b = WordBits - 1; b >= 0; b--) begin
         if (!ram_rd_data[b]) begin
            zero_found = 1'b1;
            zero_bit   = BitIdxW'(b);
         end
      end
   end

   assign alloc_id = {op_word_ff, zero_bit};

   always_comb begin
      op_mode_in  = op_mode_ff;
      op_blk_in   = op_blk_ff;
      op_found_in = op_found_ff;
      op_word_in  = op_word_ff;
      if (accept) begin
         op_mode_in  = req_chan.payload.mode;
         op_blk_in   = req_chan.payload.block_id;
         op_found_in = free_found;
         op_word_in  = (req_chan.payload.mode == MODE_FREE)
                     ? WORD_W'(req_chan.payload.block_id[BlockIdW-1:BitIdxW])
                     : free_word;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = op_word_ff;
      ram_wr_data  = ram_rd_data;
      upd_en       = 1'b0;
      upd_full     = 1'b0;
      bit_mask     = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == WORD_W'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (finish) begin
               state_in                = ST_IDLE;
               rsp_valid_in            = 1'b1;
               rsp_in.granted_block    = '0;
               if (op_mode_ff == MODE_FREE) begin
                  bit_mask[op_blk_ff[BitIdxW-1:0]] = 1'b1;
                  if (SIZE_W'(op_blk_ff) < size) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_data   = ram_rd_data & ~bit_mask;
                     upd_en        = 1'b1;
                     upd_full      = 1'b0;
                     rsp_in.status = STATUS_FREED;
                  end else begin
                     rsp_in.status = STATUS_OUT_OF_RANGE;
                  end
               end else begin
                  bit_mask[zero_bit] = 1'b1;
                  if (op_found_ff && zero_found && (CMP_W'(alloc_id) < CMP_W'(size))) begin
                     ram_wr_en            = 1'b1;
                     ram_wr_data          = ram_rd_data | bit_mask;
                     upd_en               = 1'b1;
                     upd_full             = &(ram_rd_data | bit_mask);
                     rsp_in.status        = STATUS_ALLOCATED;
                     rsp_in.granted_block = BlockIdW'(alloc_id);
                  end else begin
                     rsp_in.status = STATUS_NO_FREE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         disk_blocks_ff <= DiskBlocksReset;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            disk_blocks_ff <= csr_chan.payload.disk_blocks;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_mode_ff  <= op_mode_in;
      op_blk_ff   <= op_blk_in;
      op_word_ff  <= op_word_in;
      op_found_ff <= op_found_in;
      rsp_ff      <= rsp_in;
   end
endmodule

### test/alloc_sb_pkg.sv
`timescale 1ns / 1ps

package alloc_sb_pkg;
   import lfba_pkg::*;

   localparam int NumBlocks = NumBlocksDefault;

   class alloc_scoreboard;
      bit          used_mark [NumBlocks];
      int unsigned disk_size;
      rsp_type     expected_q[$];
      int unsigned mismatches;
      int unsigned status_seen [4];

      function new();
         disk_size = NumBlocks;
      endfunction

      // the register saturates at the number of blocks the map holds
      function void set_disk_blocks(logic [CfgW-1:0] value);
         disk_size = (value > NumBlocks) ? NumBlocks : value;
      endfunction

      function void note_request(req_type item);
         rsp_type     rsp;
         int unsigned lowest;
         rsp.status        = STATUS_NO_FREE;
         rsp.granted_block = '0;
         if (item.mode == MODE_ALLOC) begin
            lowest = NumBlocks;
            for (int i = 0; i < NumBlocks; i++) begin
               if (!used_mark[i]) begin
                  lowest = i;
                  break;
               end
            end
            // lowest free block past the disk size means nothing to grant
            if (lowest < disk_size) begin
               used_mark[lowest]  = 1'b1;
               rsp.status        = STATUS_ALLOCATED;
               rsp.granted_block = lowest[BlockIdW-1:0];
            end
         end else if (item.block_id >= disk_size) begin
            rsp.status = STATUS_OUT_OF_RANGE;
         end else begin
            used_mark[item.block_id] = 1'b0;
            rsp.status               = STATUS_FREED;
         end
         expected_q.push_back(rsp);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d block %0d", got.status,
                        got.granted_block);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("status mismatch: expected %0d, got %0d", want.status,
                        got.status);
         end
         if (got.granted_block !== want.granted_block) begin
            mismatches++;
            if (mismatches <= 10)
               $display("granted block mismatch: expected %0d, got %0d (status %0d)",
                        want.granted_block, got.granted_block, want.status);
         end
         if (!$isunknown(got.status))
            status_seen[got.status]++;
      endfunction

      function int unsigned failures();
         return mismatches + expected_q.size();
      endfunction
   endclass

endpackage

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lfba_pkg::*;
   import alloc_sb_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int NumPhases  = 13;

   logic        clock;
   logic        reset;
   int unsigned cycle_count;
   bit          quiet;
   int unsigned sizes_tried;

   alloc_scoreboard sb = new();

   lfba_chan_if #(.payload_type(req_type)) req_if ();
   lfba_chan_if #(.payload_type(rsp_type)) rsp_if ();
   lfba_chan_if #(.payload_type(csr_type)) csr_if ();

   lowest_free_block_allocator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  sb.expected_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: stall now and then unless in a quiet stretch
   always @(negedge clock) begin
      rsp_if.ready = quiet || ($urandom_range(0, 99) >= 8);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.payload);
   end

   function automatic req_type make_req(logic mode, int unsigned block);
      req_type item;
      item.mode     = mode;
      item.block_id = block[BlockIdW-1:0];
      return item;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(req_type item);
      if (!quiet && $urandom_range(0, 99) < 8) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.payload = item;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(item);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_disk_blocks(int unsigned value);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_if.valid               = 1'b1;
      csr_if.payload.disk_blocks = value[CfgW-1:0];
      do @(posedge clock); while (!csr_if.ready);
      sb.set_disk_blocks(value[CfgW-1:0]);
      sizes_tried++;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   initial begin
      int unsigned size;
      int unsigned hi;
      int unsigned alloc_pct;
      int unsigned n_items;
      req_type     item;

      reset          = 1'b1;
      quiet          = 1'b0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b1;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: default disk size of 1024
      send_request(make_req(MODE_ALLOC, 1023));
      send_request(make_req(MODE_ALLOC, 0));
      send_request(make_req(MODE_ALLOC, 10'h2AA));
      send_request(make_req(MODE_FREE, 1));
      send_request(make_req(MODE_ALLOC, 10'h155));
      send_request(make_req(MODE_FREE, 1));
      send_request(make_req(MODE_FREE, 1));       // already free
      send_request(make_req(MODE_FREE, 1023));
      send_request(make_req(MODE_FREE, 10'h2AA));
      send_request(make_req(MODE_FREE, 10'h155));
      send_request(make_req(MODE_ALLOC, 0));
      send_request(make_req(MODE_ALLOC, 0));
      // empty disk
      write_disk_blocks(0);
      send_request(make_req(MODE_ALLOC, 0));
      send_request(make_req(MODE_FREE, 0));
      send_request(make_req(MODE_FREE, 1023));
      // register above the map size saturates
      write_disk_blocks(2047);
      send_request(make_req(MODE_FREE, 1023));
      send_request(make_req(MODE_FREE, 0));
      send_request(make_req(MODE_ALLOC, 0));
      // shrunk disk: used blocks beyond the end stay used
      write_disk_blocks(1);
      send_request(make_req(MODE_ALLOC, 0));
      send_request(make_req(MODE_FREE, 2));
      send_request(make_req(MODE_FREE, 0));
      send_request(make_req(MODE_ALLOC, 0));
      send_request(make_req(MODE_ALLOC, 0));
      write_disk_blocks(3);
      send_request(make_req(MODE_ALLOC, 0));

      for (int p = 0; p < NumPhases; p++) begin
         case (p)
            0:       size = 2;
            1:       size = 64;
            2:       size = 65;
            3:       size = 130;
            4:       size = 1024;
            5:       size = 63;
            6:       size = 2047;
            7:       size = 1500;
            8:       size = 300;
            9:       size = 1023;
            10:      size = 0;
            11:      size = $urandom_range(1, 1024);
            default: size = $urandom_range(0, 2047);
         endcase
         write_disk_blocks(size);
         quiet     = (p == 3 || p == 4);
         alloc_pct = $urandom_range(55, 90);
         n_items   = (p == 4) ? 220 : 100;
         for (int i = 0; i < n_items; i++) begin
            if ((p == 1 && i == n_items / 2) || $urandom_range(0, 99) < 2)
               wait_drained();
            if ($urandom_range(0, 99) < alloc_pct) begin
               item = make_req(MODE_ALLOC, $urandom_range(0, 1023));
            end else begin
               hi = sb.disk_size + 4;
               if (hi > 1023)
                  hi = 1023;
               if ($urandom_range(0, 99) < 70)
                  item = make_req(MODE_FREE, $urandom_range(0, hi));
               else
                  item = make_req(MODE_FREE, $urandom_range(0, 1023));
            end
            send_request(item);
         end
      end
      quiet = 1'b0;

      wait_drained();
      repeat (20) @(negedge clock);

      $display("ran %0d disk size settings: %0d grants, %0d with no free block",
               sizes_tried, sb.status_seen[STATUS_ALLOCATED],
               sb.status_seen[STATUS_NO_FREE]);
      $display("%0d frees, %0d out-of-range frees, %0d mismatches",
               sb.status_seen[STATUS_FREED], sb.status_seen[STATUS_OUT_OF_RANGE],
               sb.mismatches);
      if (sb.failures() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### filelist.f
hdl/lfba_pkg.sv
hdl/lfba_chan_if.sv
hdl/lfba_ram.sv
hdl/lfba_summary.sv
hdl/lowest_free_block_allocator_unit.sv
test/alloc_sb_pkg.sv
test/tb_top.sv
